// ----- rtl/deha_pkg.sv -----
`timescale 1ns / 1ps

package deha_pkg;

  localparam int NUM_HEAPS   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RESTORE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    USE_FIXED     = 2'd0,
    USE_DEV_TEMP  = 2'd1,
    USE_DYNAMIC   = 2'd2,
    USE_HOST_ONLY = 2'd3
  } usage_t;

  typedef enum logic [1:0] {
    HEAP_DEV  = 2'd0,
    HEAP_HOST = 2'd1,
    HEAP_DYN  = 2'd2
  } heap_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_CKPT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_DEVICE_SIZE  = 2'd0,
    REG_HOST_SIZE    = 2'd1,
    REG_DYNAMIC_SIZE = 2'd2
  } cfg_reg_t;

  // Request as it arrives on the input channel
  typedef struct packed {
    logic        req_type;
    logic [1:0]  usage;
    logic [31:0] alloc_size;
    logic [4:0]  align_log2;
    logic [1:0]  heap_select;
    logic [31:0] checkpoint_low;
    logic [31:0] checkpoint_high;
  } in_item_t;

  // Result as it leaves on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [1:0]  heap_id;
    logic        host_copy;
  } out_item_t;

  // Classified command handed from the front end to the execution end
  typedef struct packed {
    logic        is_restore;
    logic        bad_heap;
    logic        at_back;
    logic        host_copy;
    heap_t       heap;
    logic [31:0] alloc_size;
    logic [31:0] align_m1;
    logic [31:0] ckpt_low;
    logic [31:0] ckpt_high;
  } cmd_t;

  // Heap presence seen by the classifier
  typedef struct packed {
    logic host_present;
    logic dyn_present;
  } heap_pres_t;

endpackage

// ----- rtl/deha_chan_if.sv -----
`timescale 1ns / 1ps

interface deha_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/deha_front.sv -----
`timescale 1ns / 1ps

module deha_front (
  deha_chan_if.sink             in_ch,
  input  deha_pkg::heap_pres_t  pres,
  input  logic                  q_full,
  output logic                  q_push,
  output deha_pkg::cmd_t        q_data
);

  deha_pkg::in_item_t req;

  assign req = in_ch.data;

  // Take a request whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify: pick the heap, the end to carve from and the alignment mask
  always_comb begin
    q_data            = '0;
    q_data.alloc_size = req.alloc_size;
    q_data.ckpt_low   = req.checkpoint_low;
    q_data.ckpt_high  = req.checkpoint_high;
    q_data.align_m1   = (32'd1 << req.align_log2) - 32'd1;
    if (req.req_type == deha_pkg::REQ_RESTORE) begin
      q_data.is_restore = 1'b1;
      if (req.heap_select > deha_pkg::HEAP_DYN) begin
        q_data.bad_heap = 1'b1;
        q_data.heap     = deha_pkg::HEAP_DEV;
      end else begin
        q_data.heap = deha_pkg::heap_t'(req.heap_select);
      end
    end else begin
      q_data.at_back   = (req.usage == deha_pkg::USE_DEV_TEMP);
      q_data.host_copy = (req.usage == deha_pkg::USE_FIXED) && pres.host_present;
      if ((req.usage == deha_pkg::USE_DYNAMIC) && pres.dyn_present) begin
        q_data.heap = deha_pkg::HEAP_DYN;
      end else if ((req.usage == deha_pkg::USE_HOST_ONLY) && pres.host_present) begin
        q_data.heap = deha_pkg::HEAP_HOST;
      end else begin
        q_data.heap = deha_pkg::HEAP_DEV;
      end
    end
  end

endmodule

// ----- rtl/deha_queue.sv -----
`timescale 1ns / 1ps

module deha_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  deha_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output deha_pkg::cmd_t head_data,
  output logic [$clog2(deha_pkg::QUEUE_DEPTH+1)-1:0] level
);

  localparam int DEPTH = deha_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  deha_pkg::cmd_t q_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]  level_r, level_nxt;

  assign full       = (level_r == LW'(DEPTH));
  assign head_valid = (level_r != '0);
  assign head_data  = q_r[rd_ptr_r];
  assign level      = level_r;

  // Advance pointers and the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/deha_back.sv -----
`timescale 1ns / 1ps

module deha_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  logic                  head_valid,
  input  deha_pkg::cmd_t        head_data,
  output logic                  pop,
  output deha_pkg::heap_pres_t  pres,
  deha_chan_if.source           out_ch
);

  localparam int NH = deha_pkg::NUM_HEAPS;
  localparam int CW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int W  = CW + 1;
  localparam int CB = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

  logic [OFFSET_BITS-1:0] size_r  [NH];
  logic [OFFSET_BITS-1:0] size_nxt [NH];
  logic [OFFSET_BITS-1:0] front_r [NH];
  logic [OFFSET_BITS-1:0] front_nxt [NH];
  logic [OFFSET_BITS-1:0] back_r  [NH];
  logic [OFFSET_BITS-1:0] back_nxt [NH];

  logic                  out_valid_r, out_valid_nxt;
  deha_pkg::out_item_t   out_data_r, out_data_nxt;

  deha_pkg::cmd_t        cmd;
  deha_pkg::out_item_t   res;
  logic [W-1:0]          front_w, back_w, size_w, align_w, gap_w;
  logic [W-1:0]          start_w, end_w, lo_w, hi_w, hsize_w;
  logic                  no_room, out_of_gap;

  assign cmd  = head_data;
  assign pres.host_present = (size_r[deha_pkg::REG_HOST_SIZE] != '0);
  assign pres.dyn_present  = (size_r[deha_pkg::REG_DYNAMIC_SIZE] != '0);

  // Take the head command when the output register is free or draining
  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Exact-width operands for the selected heap
  always_comb begin
    front_w = W'(front_r[cmd.heap]);
    back_w  = W'(back_r[cmd.heap]);
    hsize_w = W'(size_r[cmd.heap]);
    size_w  = W'(cmd.alloc_size);
    align_w = W'(cmd.align_m1);
    lo_w    = W'(cmd.ckpt_low[CB-1:0]);
    hi_w    = W'(cmd.ckpt_high[CB-1:0]);
    gap_w   = back_w - front_w;
    no_room = (back_w < front_w) || (size_w > gap_w);
    if (cmd.at_back) begin
      start_w = (back_w - size_w) & ~align_w;
    end else begin
      start_w = (front_w + align_w) & ~align_w;
    end
    end_w      = start_w + size_w;
    out_of_gap = (start_w < front_w) || (end_w > back_w);
  end

  // Execute the command and apply configuration writes
  always_comb begin
    size_nxt  = size_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    res           = '0;
    res.heap_id   = cmd.heap;
    res.host_copy = cmd.host_copy;
    if (cmd.is_restore) begin
      if (cmd.bad_heap || !((lo_w > hi_w) && (lo_w <= hsize_w) && (back_w == hi_w))) begin
        res.status = deha_pkg::ST_BAD_CKPT;
      end else begin
        res.status = deha_pkg::ST_OK;
        if (pop) begin
          back_nxt[cmd.heap] = lo_w[OFFSET_BITS-1:0];
        end
      end
    end else if (no_room || out_of_gap) begin
      res.status = deha_pkg::ST_OOM;
    end else begin
      res.status = deha_pkg::ST_OK;
      res.offset = start_w[31:0];
      if (pop) begin
        if (cmd.at_back) begin
          back_nxt[cmd.heap] = start_w[OFFSET_BITS-1:0];
        end else begin
          front_nxt[cmd.heap] = end_w[OFFSET_BITS-1:0];
        end
      end
    end
    if (cfg_we && (cfg_index <= deha_pkg::REG_DYNAMIC_SIZE)) begin
      size_nxt[cfg_index]  = OFFSET_BITS'(cfg_wdata);
      front_nxt[cfg_index] = '0;
      back_nxt[cfg_index]  = OFFSET_BITS'(cfg_wdata);
    end
  end

  // Output register: load on pop, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '{default: '0};
      front_r     <= '{default: '0};
      back_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/double_ended_heap_allocator.sv -----
`timescale 1ns / 1ps

// Double-ended heap allocator over three heaps (device, host, dynamic).
// in_ch carries requests (allocate or restore-back-checkpoint), out_ch one
// result per request, in order; both use valid/ready and a transfer happens
// when both are high. cfg_we/cfg_index/cfg_wdata write a heap size, which
// also rewinds that heap's front offset to 0 and its back offset to the size;
// write configuration only while no request is in flight.
// A request passes the classifier combinationally into a two-entry queue,
// then the execution stage reads the heap offsets, aligns, checks and updates
// them and loads the output register. A request is registered in the queue
// and its result in the output register before it transfers on out_ch;
// throughput is one request per cycle while out_ch.ready stays high, with
// each request reading, updating and writing back the offset registers.
// When the receiver stalls, the output register holds its result and the
// queue absorbs two more requests before in_ch.ready drops.
// Reset (rst_n low at a clock edge) clears all sizes and offsets to zero and
// empties the queue and output register.
module double_ended_heap_allocator #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  deha_chan_if.sink   in_ch,
  deha_chan_if.source out_ch
);

  logic                  q_push, q_pop, q_full, q_head_valid;
  deha_pkg::cmd_t        q_push_data, q_head_data;
  deha_pkg::heap_pres_t  pres;
  logic [$clog2(deha_pkg::QUEUE_DEPTH+1)-1:0] q_level;

  deha_front u_front (
    .in_ch  (in_ch),
    .pres   (pres),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  deha_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .level      (q_level)
  );

  deha_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .pres       (pres),
    .out_ch     (out_ch)
  );

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= ($clog2(deha_pkg::QUEUE_DEPTH+1))'(deha_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // A popped command always shows up as a result in the next cycle
  a_pop_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("popped command produced no result");

  // Failed allocations grant no offset
  a_oom_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.data.status == deha_pkg::ST_OOM)) |->
      (out_ch.data.offset == '0))
    else $error("out of memory result carries an offset");

  // Rejected restores carry neither offset nor host copy
  a_bad_ckpt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.data.status == deha_pkg::ST_BAD_CKPT)) |->
      ((out_ch.data.offset == '0) && !out_ch.data.host_copy))
    else $error("bad checkpoint result carries payload");

endmodule

// ----- tb/heap_alloc_checker.sv -----
`timescale 1ns / 1ps

module heap_alloc_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [31:0]                          cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  deha_pkg::in_item_t                   in_data,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  deha_pkg::out_item_t                  out_data,
  output int                                   expected_left,
  output int                                   mismatches,
  output logic [deha_pkg::NUM_HEAPS-1:0][31:0] back_seen
);

  // Shadow copy of the heap sizes and both offsets of every heap
  logic [31:0] heap_bytes [deha_pkg::NUM_HEAPS];
  logic [31:0] front_off  [deha_pkg::NUM_HEAPS];
  logic [31:0] back_off   [deha_pkg::NUM_HEAPS];

  deha_pkg::out_item_t expected_grants [$];
  int                  err_total = 0;

  assign mismatches = err_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_total++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
  endtask

  // Work out the grant for one request and update the shadow offsets
  function automatic deha_pkg::out_item_t predict_grant(input deha_pkg::in_item_t r);
    deha_pkg::out_item_t res;
    deha_pkg::heap_t     h;
    logic [33:0]         align_m1;
    logic [33:0]         start;
    logic [33:0]         stop;
    res = '0;
    if (r.req_type == deha_pkg::REQ_RESTORE) begin
      if (r.heap_select >= deha_pkg::NUM_HEAPS) begin
        // no such heap: report bad checkpoint against heap 0
        res.status = deha_pkg::ST_BAD_CKPT;
      end else begin
        res.heap_id = r.heap_select;
        if (r.checkpoint_low > r.checkpoint_high &&
            r.checkpoint_low <= heap_bytes[r.heap_select] &&
            back_off[r.heap_select] == r.checkpoint_high)
          back_off[r.heap_select] = r.checkpoint_low;
        else
          res.status = deha_pkg::ST_BAD_CKPT;
      end
    end else begin
      // pick the heap; absent dynamic or host heaps fall back to device
      h = deha_pkg::HEAP_DEV;
      if (r.usage == deha_pkg::USE_DYNAMIC && heap_bytes[deha_pkg::HEAP_DYN] != 0)
        h = deha_pkg::HEAP_DYN;
      if (r.usage == deha_pkg::USE_HOST_ONLY && heap_bytes[deha_pkg::HEAP_HOST] != 0)
        h = deha_pkg::HEAP_HOST;
      res.heap_id   = h;
      res.host_copy = (r.usage == deha_pkg::USE_FIXED) &&
                      (heap_bytes[deha_pkg::HEAP_HOST] != 0);
      align_m1 = (34'd1 << r.align_log2) - 34'd1;
      if (back_off[h] < front_off[h] || r.alloc_size > back_off[h] - front_off[h]) begin
        res.status = deha_pkg::ST_OOM;
      end else begin
        // temporary device space comes off the back, aligned down
        if (r.usage == deha_pkg::USE_DEV_TEMP)
          start = ({2'b00, back_off[h]} - {2'b00, r.alloc_size}) & ~align_m1;
        else
          start = ({2'b00, front_off[h]} + align_m1) & ~align_m1;
        stop = start + {2'b00, r.alloc_size};
        if (start < {2'b00, front_off[h]} || stop > {2'b00, back_off[h]}) begin
          res.status = deha_pkg::ST_OOM;
        end else begin
          res.offset = start[31:0];
          if (r.usage == deha_pkg::USE_DEV_TEMP) back_off[h] = start[31:0];
          else front_off[h] = stop[31:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    deha_pkg::out_item_t want;
    if (!rst_n) begin
      for (int h = 0; h < deha_pkg::NUM_HEAPS; h++) begin
        heap_bytes[h] = '0;
        front_off[h]  = '0;
        back_off[h]   = '0;
      end
      expected_grants.delete();
    end else begin
      // a size write rewinds that heap
      if (cfg_we && cfg_index < deha_pkg::NUM_HEAPS) begin
        heap_bytes[cfg_index] = cfg_wdata;
        front_off[cfg_index]  = '0;
        back_off[cfg_index]   = cfg_wdata;
      end
      // compare each result transfer against the oldest grant
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_grants.pop_front();
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("offset", out_data.offset, want.offset);
          check_field("heap_id", 32'(out_data.heap_id), 32'(want.heap_id));
          check_field("host_copy", 32'(out_data.host_copy), 32'(want.host_copy));
        end
      end
      if (in_valid && in_ready)
        expected_grants.push_back(predict_grant(in_data));
    end
    // publish with NBAs so the stimulus always reads pre-edge values
    expected_left <= expected_grants.size();
    for (int h = 0; h < deha_pkg::NUM_HEAPS; h++)
      back_seen[h] <= back_off[h];
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int ITEMS       = 1100;
  localparam int PHASES      = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NH          = deha_pkg::NUM_HEAPS;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  deha_chan_if #(.T(deha_pkg::in_item_t))  in_ch ();
  deha_chan_if #(.T(deha_pkg::out_item_t)) out_ch ();

  int                  expected_left;
  int                  mismatches;
  logic [NH-1:0][31:0] back_seen;

  logic [31:0] heap_bytes [NH];
  logic [31:0] mark       [NH];
  int          burst_left    = 1;
  int          items_sent    = 0;
  int          hold_requests = 0;
  int          cycle_count   = 0;
  bit          offering      = 1'b0;

  double_ended_heap_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  heap_alloc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .expected_left (expected_left),
    .mismatches    (mismatches),
    .back_seen     (back_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall patterns, plus long hold-offs on request
  initial begin : rx_side
    rx_mode_t mode;
    int       mode_left;
    int       holds_done;
    mode       = RX_OPEN;
    mode_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  out_ch.ready <= 1'b1;
          RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  out_ch.ready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  function automatic deha_pkg::in_item_t mk_alloc(input deha_pkg::usage_t u,
                                                  input logic [31:0] len,
                                                  input logic [4:0] alog);
    deha_pkg::in_item_t r;
    r.req_type        = deha_pkg::REQ_ALLOC;
    r.usage           = u;
    r.alloc_size      = len;
    r.align_log2      = alog;
    r.heap_select     = 2'($urandom_range(0, 3));
    r.checkpoint_low  = $urandom;
    r.checkpoint_high = $urandom;
    return r;
  endfunction

  function automatic deha_pkg::in_item_t mk_restore(input logic [1:0] sel,
                                                    input logic [31:0] lo,
                                                    input logic [31:0] hi);
    deha_pkg::in_item_t r;
    r.req_type        = deha_pkg::REQ_RESTORE;
    r.usage           = 2'($urandom_range(0, 3));
    r.alloc_size      = $urandom;
    r.align_log2      = 5'($urandom_range(0, 31));
    r.heap_select     = sel;
    r.checkpoint_low  = lo;
    r.checkpoint_high = hi;
    return r;
  endfunction

  function automatic logic [31:0] pick_len(input logic [31:0] room);
    logic [31:0] len;
    case ($urandom_range(0, 9))
      0:       len = $urandom;
      1:       len = '0;
      2:       len = room;
      default: len = $urandom_range(0, room / 16 + 1);
    endcase
    return len;
  endfunction

  function automatic logic [4:0] pick_align();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 6));
  endfunction

  function automatic logic [31:0] pick_heap_size();
    logic [31:0] bytes;
    case ($urandom_range(0, 7))
      0:       bytes = '0;
      1:       bytes = '1;
      2:       bytes = $urandom;
      3:       bytes = $urandom_range(1, 1 << 20);
      default: bytes = $urandom_range(1, 8192);
    endcase
    return bytes;
  endfunction

  // Offer one request and hold it until the transfer; close bursts with gaps
  task automatic offer(input deha_pkg::in_item_t r);
    int gap;
    in_ch.data  <= r;
    in_ch.valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every result is back and the pipe is empty
  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (expected_left != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_heap_sizes(input logic [31:0] dev, input logic [31:0] host,
                                input logic [31:0] dyn);
    deha_pkg::cfg_reg_t order [NH] = '{deha_pkg::REG_DEVICE_SIZE,
                                       deha_pkg::REG_HOST_SIZE,
                                       deha_pkg::REG_DYNAMIC_SIZE};
    heap_bytes = '{dev, host, dyn};
    mark       = heap_bytes;
    cfg_we <= 1'b1;
    for (int i = 0; i < NH; i++) begin
      cfg_index <= order[i];
      cfg_wdata <= heap_bytes[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    deha_pkg::in_item_t r;
    deha_pkg::usage_t   u;
    logic [1:0]         sel;
    logic [31:0]        lo;
    logic [31:0]        hi;
    logic [31:0]        room;
    int                 pick;
    int                 phase_end;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= deha_pkg::REG_DEVICE_SIZE;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    heap_bytes   = '{32'd0, 32'd0, 32'd0};
    mark         = heap_bytes;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty heaps: a zero-byte request fits, one byte does not
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd0, 5'd0));
    offer(mk_alloc(deha_pkg::USE_DEV_TEMP, 32'd1, 5'd0));
    drain();

    // Small heaps, dynamic absent
    set_heap_sizes(32'd4096, 32'd1024, 32'd0);
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd100, 5'd0));
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd10, 5'd4));
    offer(mk_alloc(deha_pkg::USE_DEV_TEMP, 32'd64, 5'd6));
    // aligning down falls below the front
    offer(mk_alloc(deha_pkg::USE_DEV_TEMP, 32'd1, 5'd31));
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'hFFFF_FFFF, 5'd0));
    // dynamic heap absent: falls back to device
    offer(mk_alloc(deha_pkg::USE_DYNAMIC, 32'd8, 5'd3));
    offer(mk_alloc(deha_pkg::USE_HOST_ONLY, 32'd1024, 5'd31));
    offer(mk_alloc(deha_pkg::USE_HOST_ONLY, 32'd1, 5'd0));
    // restore of a heap that does not exist
    offer(mk_restore(2'd3, 32'd4096, 32'd4032));
    offer(mk_restore(deha_pkg::HEAP_DEV, 32'd4096, 32'd4032));
    // stale checkpoint, low not above high, low beyond the heap
    offer(mk_restore(deha_pkg::HEAP_DEV, 32'd4096, 32'd4032));
    offer(mk_restore(deha_pkg::HEAP_DEV, 32'd4000, 32'd4096));
    offer(mk_restore(deha_pkg::HEAP_DEV, 32'd5000, 32'd4096));
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd0, 5'd31));
    drain();

    // Full-range heaps, host absent
    set_heap_sizes(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    offer(mk_alloc(deha_pkg::USE_DYNAMIC, 32'hFFFF_FFFF, 5'd0));
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd16, 5'd0));
    offer(mk_alloc(deha_pkg::USE_DEV_TEMP, 32'h4000_0000, 5'd31));
    offer(mk_alloc(deha_pkg::USE_FIXED, 32'd0, 5'd31));
    // host heap absent: device is full
    offer(mk_alloc(deha_pkg::USE_HOST_ONLY, 32'd5, 5'd0));
    offer(mk_restore(deha_pkg::HEAP_DEV, 32'hFFFF_FFFF, 32'h8000_0000));
    offer(mk_alloc(deha_pkg::USE_DEV_TEMP, 32'hFFFF_FFFF, 5'd0));
    offer(mk_restore(deha_pkg::HEAP_HOST, 32'd1, 32'd0));
    drain();

    // Random phases, each with fresh heap sizes
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) set_heap_sizes(32'd0, 32'hFFFF_FFFF, 32'd0);
      else if (phase == 1) set_heap_sizes('1, '1, '1);
      else set_heap_sizes(pick_heap_size(), pick_heap_size(), pick_heap_size());
      // stall the result side for a long stretch while requests keep coming
      if (phase == 2 || phase == 6) hold_requests <= hold_requests + 1;
      phase_end = items_sent + ITEMS / PHASES;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // front allocation sized against the heap it will likely land in
          case ($urandom_range(0, 2))
            0:       u = deha_pkg::USE_FIXED;
            1:       u = deha_pkg::USE_DYNAMIC;
            default: u = deha_pkg::USE_HOST_ONLY;
          endcase
          room = heap_bytes[deha_pkg::HEAP_DEV];
          if (u == deha_pkg::USE_DYNAMIC && heap_bytes[deha_pkg::HEAP_DYN] != 0)
            room = heap_bytes[deha_pkg::HEAP_DYN];
          if (u == deha_pkg::USE_HOST_ONLY && heap_bytes[deha_pkg::HEAP_HOST] != 0)
            room = heap_bytes[deha_pkg::HEAP_HOST];
          offer(mk_alloc(u, pick_len(room), pick_align()));
        end else if (pick < 65) begin
          offer(mk_alloc(deha_pkg::USE_DEV_TEMP, pick_len(heap_bytes[deha_pkg::HEAP_DEV]),
                         pick_align()));
        end else if (pick < 80) begin
          // a front allocation lets the back offsets settle, then rewind
          offer(mk_alloc(deha_pkg::USE_FIXED, 32'($urandom_range(0, 64)),
                         5'($urandom_range(0, 4))));
          sel = 2'($urandom_range(0, 2));
          hi  = back_seen[sel];
          lo  = ($urandom_range(0, 1) == 1 && mark[sel] > hi) ? mark[sel] : heap_bytes[sel];
          if ($urandom_range(0, 3) == 0) mark[sel] = hi;
          offer(mk_restore(sel, lo, hi));
        end else if (pick < 90) begin
          // broken restore
          sel = 2'($urandom_range(0, 3));
          hi  = (sel < NH) ? back_seen[sel] : $urandom;
          case ($urandom_range(0, 3))
            0: lo = hi;
            1: lo = hi - 32'($urandom_range(1, 64));
            2: lo = (sel < NH) ? heap_bytes[sel] + 32'd1 : $urandom;
            default: begin
              lo = $urandom;
              hi = $urandom;
            end
          endcase
          offer(mk_restore(sel, lo, hi));
        end else begin
          // raw noise over every field
          r.req_type        = 1'($urandom_range(0, 1));
          r.usage           = 2'($urandom_range(0, 3));
          r.alloc_size      = $urandom;
          r.align_log2      = 5'($urandom_range(0, 31));
          r.heap_select     = 2'($urandom_range(0, 3));
          r.checkpoint_low  = $urandom;
          r.checkpoint_high = $urandom;
          offer(r);
        end
      end
      drain();
    end

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
